// File: hdl/sll_pkg.sv
package sll_pkg;

  localparam int unsigned FracBits     = 16;
  localparam int unsigned MaxImages    = 1024;
  localparam int unsigned MaxChannels  = 64;
  localparam int unsigned MaxPositions = 4096;
  localparam int unsigned NormW        = 39;
  localparam int unsigned DivW         = 80;
  localparam int unsigned StepW        = 7;
  localparam int unsigned SlotW        = 12;
  localparam int unsigned LossW        = 52;

  localparam logic [StepW-1:0] GradSteps  = 7'd48;
  localparam logic [StepW-1:0] TotalSteps = 7'd80;
  localparam logic [LossW-1:0] Max52      = {LossW{1'b1}};
  localparam logic [NormW-1:0] OneQ       = 39'd65536;

  typedef enum logic [2:0] {
    CFG_NORM_MODE     = 3'd0,
    CFG_PREFIXED_NORM = 3'd1,
    CFG_NUM_IMAGES    = 3'd2,
    CFG_NUM_CHANNELS  = 3'd3,
    CFG_NUM_POSITIONS = 3'd4,
    CFG_USE_WEIGHTS   = 3'd5,
    CFG_GRAD_SCALE    = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    NORM_FULL     = 3'd0,
    NORM_VALID    = 3'd1,
    NORM_BATCH    = 3'd2,
    NORM_PREFIXED = 3'd3
  } norm_mode_e;

  typedef struct packed {
    logic [2:0]         norm_mode;
    logic [30:0]        prefixed_norm;
    logic [10:0]        num_images;
    logic [6:0]         num_channels;
    logic [12:0]        num_positions;
    logic               use_weights;
    logic signed [31:0] grad_scale;
  } cfg_t;

  typedef struct packed {
    logic             capture;
    logic             mul_en;
    logic             sat_en;
    logic             err_en;
    logic             acc_en;
    logic             div_grad;
    logic             div_total;
    logic             grad_en;
    logic             total_en;
    logic             out_load;
    logic             first_chan;
    logic             last_chan;
    logic             last_batch;
    logic [SlotW-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic logic [10:0] clamp_imgs(input logic [10:0] v);
    if (v == 11'd0) return 11'd1;
    return (v > 11'(MaxImages)) ? 11'(MaxImages) : v;
  endfunction

  function automatic logic [6:0] clamp_chans(input logic [6:0] v);
    if (v == 7'd0) return 7'd1;
    return (v > 7'(MaxChannels)) ? 7'(MaxChannels) : v;
  endfunction

  function automatic logic [12:0] clamp_poss(input logic [12:0] v);
    if (v == 13'd0) return 13'd1;
    return (v > 13'(MaxPositions)) ? 13'(MaxPositions) : v;
  endfunction

  function automatic logic [NormW-1:0] norm_calc(input cfg_t c);
    logic [23:0]      area;
    logic [NormW-1:0] n;
    area = 24'(clamp_imgs(c.num_images)) * 24'(clamp_poss(c.num_positions));
    unique case (c.norm_mode)
      NORM_FULL, NORM_VALID: n = NormW'(area) << FracBits;
      NORM_BATCH:            n = NormW'(clamp_imgs(c.num_images)) << FracBits;
      NORM_PREFIXED:         n = NormW'(c.prefixed_norm);
      default:               n = OneQ;
    endcase
    return (n < OneQ) ? OneQ : n;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [48:0] x);
    if (x > 49'sd2147483647) return 32'sh7fffffff;
    if (x < -49'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

endpackage

// File: hdl/sll_div.sv
module sll_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sll_pkg::DivW-1:0]  dividend_i,
  input  logic [sll_pkg::NormW-1:0] divisor_i,
  input  logic [sll_pkg::StepW-1:0] steps_i,
  output logic [sll_pkg::DivW-1:0]  quot_o,
  output logic                      done_o
);
  import sll_pkg::*;

  logic [DivW-1:0]  sh_q, sh_d;
  logic [NormW-1:0] rem_q, rem_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             act_q, act_d;
  logic [NormW:0]   trial;
  logic             ge;

  assign trial = {rem_q, sh_q[DivW-1]};
  assign ge    = trial >= {1'b0, divisor_i};

  always_comb begin
    sh_d  = sh_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    act_d = act_q;
    if (start_i) begin
      sh_d  = dividend_i;
      rem_d = '0;
      cnt_d = steps_i;
      act_d = 1'b1;
    end else if (act_q) begin
      if (cnt_q != '0) begin
        rem_d = ge ? NormW'(trial - {1'b0, divisor_i}) : trial[NormW-1:0];
        sh_d  = {sh_q[DivW-2:0], ge};
        cnt_d = cnt_q - 1'b1;
      end else begin
        act_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      act_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      act_q <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign quot_o = sh_q;
  assign done_o = act_q && (cnt_q == '0);

endmodule

// File: hdl/sll_dp.sv
module sll_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sll_pkg::cfg_t             cfg_i,
  input  sll_pkg::cmd_t             cmd_i,
  output sll_pkg::sts_t             sts_o,
  input  logic [95:0]               in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [135:0]              out_data_o,
  output logic                      out_pvalid_o,
  output logic                      out_tvalid_o
);
  import sll_pkg::*;

  logic signed [31:0]  p, t, w;
  logic signed [31:0]  w_q;
  logic signed [32:0]  diff_q;
  logic signed [64:0]  wprod_q;
  logic signed [48:0]  wshift;
  logic signed [31:0]  d_q;
  logic [31:0]         mag;
  logic [31:0]         sq;
  logic [31:0]         err, err_q;
  logic signed [17:0]  c;
  logic signed [49:0]  gprod, gprod_q;
  logic [49:0]         gabs;
  logic [NormW-1:0]    norm_q;
  logic [LossW-1:0]    mem [MaxPositions];
  logic [LossW-1:0]    rd_q;
  logic [LossW:0]      psum_add;
  logic [LossW-1:0]    psum_d, psum_q;
  logic [64:0]         bsum_add;
  logic [63:0]         bsum_q, bsum_d;
  logic                lc_q, lb_q;
  logic [DivW-1:0]     dividend, quot;
  logic [StepW-1:0]    steps;
  logic                div_done;
  logic signed [31:0]  grad_q, grad_d;
  logic [LossW-1:0]    total_q;
  logic                ovalid_q, ovalid_d;
  logic [135:0]        odata_q;
  logic                opv_q, otv_q;

  assign p = in_data_i[31:0];
  assign t = in_data_i[63:32];
  assign w = in_data_i[95:64];

  assign wshift = 49'(wprod_q >>> FracBits);
  assign mag    = d_q[31] ? 32'(-d_q) : 32'(d_q);
  assign sq     = 32'(mag[15:0]) * 32'(mag[15:0]);
  assign err    = (mag < 32'd65536) ? (sq >> (FracBits + 1)) : (mag - 32'd32768);

  always_comb begin
    if (d_q > 32'sd65536)       c = 18'sd65536;
    else if (d_q < -32'sd65536) c = -18'sd65536;
    else                        c = 18'(d_q);
  end
  assign gprod = 50'(c) * 50'(cfg_i.grad_scale);
  assign gabs  = gprod_q[49] ? 50'(-gprod_q) : 50'(gprod_q);

  assign psum_add = {1'b0, rd_q} + (LossW+1)'(err_q);
  assign psum_d   = cmd_i.first_chan ? LossW'(err_q) :
                    (psum_add[LossW] ? Max52 : psum_add[LossW-1:0]);
  assign bsum_add = {1'b0, bsum_q} + 65'(err_q);

  always_comb begin
    bsum_d = bsum_q;
    if (cmd_i.acc_en)        bsum_d = bsum_add[64] ? {64{1'b1}} : bsum_add[63:0];
    else if (cmd_i.total_en) bsum_d = '0;
  end

  assign dividend = cmd_i.div_total ? {bsum_q, 16'd0} : {gabs[47:0], 32'd0};
  assign steps    = cmd_i.div_total ? TotalSteps : GradSteps;

  sll_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_grad | cmd_i.div_total),
    .dividend_i (dividend),
    .divisor_i  (norm_q),
    .steps_i    (steps),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  always_comb begin
    if (gprod_q[49]) grad_d = (quot[47:0] > 48'd2147483648) ? 32'sh80000000 : 32'(-quot[31:0]);
    else             grad_d = (quot[47:0] > 48'd2147483647) ? 32'sh7fffffff : quot[31:0];
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (cmd_i.out_load)   ovalid_d = 1'b1;
    else if (out_ready_i) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsum_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      bsum_q   <= bsum_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      diff_q <= 33'(p) - 33'(t);
      w_q    <= w;
      norm_q <= norm_calc(cfg_i);
    end
    if (cmd_i.mul_en) wprod_q <= 65'(diff_q) * 65'(w_q);
    if (cmd_i.sat_en) d_q <= sat32(cfg_i.use_weights ? wshift : 49'(diff_q));
    if (cmd_i.err_en) begin
      err_q   <= err;
      gprod_q <= gprod;
    end
    if (cmd_i.acc_en) begin
      psum_q <= psum_d;
      lc_q   <= cmd_i.last_chan;
      lb_q   <= cmd_i.last_batch;
    end
    if (cmd_i.grad_en)  grad_q  <= grad_d;
    if (cmd_i.total_en) total_q <= (quot[DivW-1:LossW] != '0) ? Max52 : quot[LossW-1:0];
    if (cmd_i.out_load) begin
      odata_q <= {(lb_q ? total_q : {LossW{1'b0}}), (lc_q ? psum_q : {LossW{1'b0}}), grad_q};
      opv_q   <= lc_q;
      otv_q   <= lb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) rd_q <= mem[cmd_i.slot];
    if (cmd_i.acc_en)  mem[cmd_i.slot] <= psum_d;
  end

  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !ovalid_q || out_ready_i;
  assign out_valid_o    = ovalid_q;
  assign out_data_o     = odata_q;
  assign out_pvalid_o   = opv_q;
  assign out_tvalid_o   = otv_q;

endmodule

// File: hdl/sll_ctrl.sv
module sll_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sll_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  sll_pkg::sts_t sts_i,
  output sll_pkg::cmd_t cmd_o
);
  import sll_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_MUL  = 8'b0000_0010,
    ST_SAT  = 8'b0000_0100,
    ST_ERR  = 8'b0000_1000,
    ST_ACC  = 8'b0001_0000,
    ST_DIVG = 8'b0010_0000,
    ST_DIVT = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_e;

  state_e      state_q, state_d;
  logic [11:0] pos_q, pos_d;
  logic [5:0]  chan_q, chan_d;
  logic [9:0]  img_q, img_d;
  logic        lb_q, lb_d;
  logic        last_pos, last_chan, last_img;

  assign last_pos  = (13'(pos_q) + 13'd1)  >= clamp_poss(cfg_i.num_positions);
  assign last_chan = (7'(chan_q) + 7'd1)   >= clamp_chans(cfg_i.num_channels);
  assign last_img  = (11'(img_q) + 11'd1)  >= clamp_imgs(cfg_i.num_images);

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    chan_d  = chan_q;
    img_d   = img_q;
    lb_d    = lb_q;
    cmd_o   = '0;
    cmd_o.slot       = pos_q;
    cmd_o.first_chan = (chan_q == '0);
    cmd_o.last_chan  = last_chan;
    cmd_o.last_batch = last_pos && last_chan && last_img;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d = ST_SAT;
      end
      ST_SAT: begin
        cmd_o.sat_en = 1'b1;
        state_d = ST_ERR;
      end
      ST_ERR: begin
        cmd_o.err_en = 1'b1;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc_en   = 1'b1;
        cmd_o.div_grad = 1'b1;
        lb_d = last_pos && last_chan && last_img;
        if (last_pos) begin
          pos_d = '0;
          if (last_chan) begin
            chan_d = '0;
            img_d  = last_img ? '0 : img_q + 1'b1;
          end else begin
            chan_d = chan_q + 1'b1;
          end
        end else begin
          pos_d = pos_q + 1'b1;
        end
        state_d = ST_DIVG;
      end
      ST_DIVG: begin
        if (sts_i.div_done) begin
          cmd_o.grad_en = 1'b1;
          if (lb_q) begin
            cmd_o.div_total = 1'b1;
            state_d = ST_DIVT;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DIVT: begin
        if (sts_i.div_done) begin
          cmd_o.total_en = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
      chan_q  <= '0;
      img_q   <= '0;
      lb_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      chan_q  <= chan_d;
      img_q   <= img_d;
      lb_q    <= lb_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

// File: hdl/smooth_l1_loss_engine_core.sv
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: prediction, target, weight
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: pred_grad, position_loss,
//                                              total_loss; tuser/tlast: flags
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One word at a time. Each uses the shared one-bit-per-cycle divider (48
// steps for the gradient, 80 more for the total on a batch's last word).
// No clearing pass after reset. The result register lets the next word
// in while a result waits on m_axis.
module smooth_l1_loss_engine_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // prediction[31:0], target[63:32], weight[95:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,  // pred_grad[31:0], position_loss[83:32],
                                      // total_loss[135:84]
  output logic         m_axis_tuser,  // position_valid
  output logic         m_axis_tlast,  // total_valid
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import sll_pkg::*;

  cfg_t cfg_q, cfg_d;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NORM_MODE:     cfg_d.norm_mode     = cfg_data_i[2:0];
        CFG_PREFIXED_NORM: cfg_d.prefixed_norm = cfg_data_i[30:0];
        CFG_NUM_IMAGES:    cfg_d.num_images    = cfg_data_i[10:0];
        CFG_NUM_CHANNELS:  cfg_d.num_channels  = cfg_data_i[6:0];
        CFG_NUM_POSITIONS: cfg_d.num_positions = cfg_data_i[12:0];
        CFG_USE_WEIGHTS:   cfg_d.use_weights   = cfg_data_i[0];
        CFG_GRAD_SCALE:    cfg_d.grad_scale    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.norm_mode     <= 3'd0;
      cfg_q.prefixed_norm <= 31'd65536;
      cfg_q.num_images    <= 11'd1;
      cfg_q.num_channels  <= 7'd1;
      cfg_q.num_positions <= 13'd1;
      cfg_q.use_weights   <= 1'b0;
      cfg_q.grad_scale    <= 32'sd65536;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  sll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sll_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_data_i    (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_pvalid_o (m_axis_tuser),
    .out_tvalid_o (m_axis_tlast)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a word is in flight");

  a_batch_end_on_last_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
    else $error("batch end without last channel");

  a_loss_zero_off_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[83:32] == '0)
    else $error("position loss on inner channel");

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten");
`endif

endmodule

// File: tb/sv/smooth_l1_loss_engine_core_tb.sv
`timescale 1ns / 1ps

module smooth_l1_loss_engine_core_tb;
  import sll_pkg::*;

  localparam logic [2:0] NormNone    = 3'd4;
  localparam logic [2:0] NormUnknown = 3'd7;
  localparam longint unsigned OneQL  = 64'd65536;
  localparam longint unsigned Max52L = (64'd1 << 52) - 64'd1;

  typedef struct {
    logic signed [31:0] pred;
    logic signed [31:0] targ;
    logic signed [31:0] wgt;
  } elem_t;

  typedef struct {
    logic signed [31:0] grad;
    logic [51:0]        pos_loss;
    logic               pos_valid;
    logic [51:0]        tot_loss;
    logic               tot_valid;
  } loss_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         m_axis_tlast;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  smooth_l1_loss_engine_core dut (.*);

  // shadow of the register file
  logic [2:0]         mode_r;
  logic [30:0]        pnorm_r;
  logic [10:0]        imgs_r;
  logic [6:0]         chans_r;
  logic [12:0]        poss_r;
  logic               wts_r;
  logic signed [31:0] gscale_r;

  longint unsigned pos_sums[MaxPositions];
  longint unsigned batch_acc;
  int unsigned     img_cnt, chan_cnt, pos_cnt;

  elem_t pending_q[$];
  loss_t loss_q[$];
  elem_t cur_elem;
  int    errors = 0;
  int    gap = 0, stall = 0;
  bit    calm = 1'b0;
  int    rand_words = 0;

  initial forever #2 clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned dim_of(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic longint unsigned norm_of();
    longint unsigned n;
    case (mode_r)
      NORM_FULL, NORM_VALID:
        n = (longint'(dim_of(imgs_r, MaxImages)) * dim_of(poss_r, MaxPositions)) << FracBits;
      NORM_BATCH:    n = longint'(dim_of(imgs_r, MaxImages)) << FracBits;
      NORM_PREFIXED: n = pnorm_r;
      default:       n = OneQL;
    endcase
    return (n < OneQL) ? OneQL : n;
  endfunction

  function automatic loss_t smooth_l1_step(input elem_t e);
    longint          d, c, prod;
    longint unsigned mag, err, q, r, nrm, frac, tot;
    int unsigned     slot, poss, chans, imgs;
    bit              lp, lc, li;
    loss_t           res;
    imgs  = dim_of(imgs_r, MaxImages);
    chans = dim_of(chans_r, MaxChannels);
    poss  = dim_of(poss_r, MaxPositions);
    nrm   = norm_of();
    d = longint'(e.pred) - longint'(e.targ);
    if (wts_r) d = (d * longint'(e.wgt)) >>> FracBits;
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    mag = (d < 0) ? longint'(-d) : d;
    err = (mag < OneQL) ? (mag * mag) >> (FracBits + 1) : mag - (OneQL >> 1);
    c = d;
    if (c > 64'sd65536) c = 64'sd65536;
    if (c < -64'sd65536) c = -64'sd65536;
    prod = c * longint'(gscale_r);
    if (prod >= 0) begin
      q = longint'(prod) / nrm;
      res.grad = (q > 64'd2147483647) ? 32'sh7fffffff : q[31:0];
    end else begin
      q = longint'(-prod) / nrm;
      res.grad = (q > 64'd2147483648) ? 32'sh80000000 : 32'(-longint'(q));
    end
    slot = (pos_cnt >= MaxPositions) ? MaxPositions - 1 : pos_cnt;
    if (chan_cnt == 0) pos_sums[slot] = err;
    else pos_sums[slot] = (pos_sums[slot] + err > Max52L) ? Max52L : pos_sums[slot] + err;
    batch_acc = (batch_acc + err < batch_acc) ? 64'hffff_ffff_ffff_ffff : batch_acc + err;
    lp = pos_cnt + 1 >= poss;
    lc = chan_cnt + 1 >= chans;
    li = img_cnt + 1 >= imgs;
    res.pos_valid = lc;
    res.pos_loss  = lc ? pos_sums[slot][51:0] : '0;
    res.tot_valid = lp && lc && li;
    res.tot_loss  = '0;
    if (res.tot_valid) begin
      q = batch_acc / nrm;
      r = batch_acc % nrm;
      if (q > (Max52L >> FracBits)) tot = Max52L;
      else begin
        frac = 0;
        for (int i = 0; i < FracBits; i++) begin
          r = r << 1;
          frac = frac << 1;
          if (r >= nrm) begin
            r = r - nrm;
            frac = frac | 1;
          end
        end
        tot = (q << FracBits) + frac;
        if (tot > Max52L) tot = Max52L;
      end
      res.tot_loss = tot[51:0];
      batch_acc = 0;
    end
    if (lp) begin
      pos_cnt = 0;
      if (lc) begin
        chan_cnt = 0;
        img_cnt = li ? 0 : img_cnt + 1;
      end else chan_cnt++;
    end else pos_cnt++;
    return res;
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) loss_q.push_back(smooth_l1_step(cur_elem));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap > 0) begin
          gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          cur_elem = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {cur_elem.wgt, cur_elem.targ, cur_elem.pred};
          if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 6);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("%0t mismatch %s: got %h, want %h", $realtime, what, got, want);
  endtask

  // receiver
  always @(posedge clk_i) begin
    loss_t w;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (loss_q.size() == 0) report_mismatch("unexpected word", m_axis_tdata[63:0], '0);
        else begin
          w = loss_q.pop_front();
          if (m_axis_tdata[31:0] !== w.grad) report_mismatch("pred_grad", m_axis_tdata[31:0], w.grad);
          if (m_axis_tdata[83:32] !== w.pos_loss)
            report_mismatch("position_loss", m_axis_tdata[83:32], w.pos_loss);
          if (m_axis_tuser !== w.pos_valid)
            report_mismatch("position_valid", m_axis_tuser, w.pos_valid);
          if (m_axis_tdata[135:84] !== w.tot_loss)
            report_mismatch("total_loss", m_axis_tdata[135:84], w.tot_loss);
          if (m_axis_tlast !== w.tot_valid)
            report_mismatch("total_valid", m_axis_tlast, w.tot_valid);
        end
      end
      if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 6);
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_NORM_MODE:     mode_r   = v[2:0];
      CFG_PREFIXED_NORM: pnorm_r  = v[30:0];
      CFG_NUM_IMAGES:    imgs_r   = v[10:0];
      CFG_NUM_CHANNELS:  chans_r  = v[6:0];
      CFG_NUM_POSITIONS: poss_r   = v[12:0];
      CFG_USE_WEIGHTS:   wts_r    = v[0];
      CFG_GRAD_SCALE:    gscale_r = v;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || s_axis_tvalid || loss_q.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($urandom_range(0, 2)) == 0 ? 32'h7fffffff :
                ($urandom_range(0, 1) ? 32'h80000000 : 32'h0);
      default: return $urandom_range(0, 1) ? $urandom_range(0, 32'h30000)
                                           : -$urandom_range(0, 32'h30000);
    endcase
  endfunction

  function automatic elem_t rand_elem();
    elem_t e;
    e.targ = rand_q();
    e.pred = $urandom_range(0, 3) == 0 ? rand_q() : e.targ + rand_q();
    e.wgt  = $urandom_range(0, 2) == 0 ? rand_q() : $urandom_range(0, 32'h28000);
    return e;
  endfunction

  task automatic push_elem(input logic [31:0] p, input logic [31:0] t, input logic [31:0] w);
    elem_t e;
    e.pred = p;
    e.targ = t;
    e.wgt  = w;
    pending_q.push_back(e);
  endtask

  // counters back to zero via a 1x1x1 batch, then a full register set
  task automatic set_cfg(input logic [2:0] mode, input logic [31:0] pnorm,
                         input logic [31:0] imgs, input logic [31:0] chans,
                         input logic [31:0] poss, input logic wts, input logic [31:0] gs);
    write_reg(CFG_NUM_IMAGES, 1);
    write_reg(CFG_NUM_CHANNELS, 1);
    write_reg(CFG_NUM_POSITIONS, 1);
    pending_q.push_back(rand_elem());
    drain();
    write_reg(CFG_NORM_MODE, mode);
    write_reg(CFG_PREFIXED_NORM, pnorm);
    write_reg(CFG_NUM_IMAGES, imgs);
    write_reg(CFG_NUM_CHANNELS, chans);
    write_reg(CFG_NUM_POSITIONS, poss);
    write_reg(CFG_USE_WEIGHTS, wts);
    write_reg(CFG_GRAD_SCALE, gs);
  endtask

  task automatic push_rand(input int n);
    repeat (n) pending_q.push_back(rand_elem());
  endtask

  initial begin
    int unsigned size;
    mode_r = NORM_FULL; pnorm_r = 31'd65536; imgs_r = 1; chans_r = 1; poss_r = 1;
    wts_r = 1'b0; gscale_r = 32'sd65536;
    batch_acc = 0; img_cnt = 0; chan_cnt = 0; pos_cnt = 0;
    foreach (pos_sums[i]) pos_sums[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: difference saturation and the quadratic/linear boundary
    push_elem(32'h7fffffff, 32'h80000000, 0);
    push_elem(32'h80000000, 32'h7fffffff, 0);
    push_elem(32'h12345678, 32'h12345678, 0);
    push_elem(32'h00010000, 32'h0, 0);
    push_elem(32'h0000ffff, 32'h0, 0);
    push_elem(32'h0, 32'h00010001, 0);
    push_elem(32'hffff0000, 32'h0, 0);
    push_elem(32'h00000001, 32'h0, 32'hffffffff);
    drain();

    // weighted, floored product, gradient saturation, no normaliser
    set_cfg(NormNone, 32'h0, 1, 1, 1, 1'b1, 32'h80000000);
    push_elem(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    push_elem(32'h7fffffff, 32'h80000000, 32'h80000000);
    push_elem(32'h00000003, 32'h0, 32'hffff8000);
    push_elem(32'hffff0000, 32'h0, 32'h00010000);
    push_elem(32'h00000001, 32'h0, 32'h00000001);
    drain();
    set_cfg(NormUnknown, 32'hffffffff, 0, 0, 0, 1'b0, 32'h7fffffff);
    push_elem(32'h00010000, 32'h0, 0);
    push_elem(32'h80000000, 32'h0, 0);
    drain();

    // channel count above the maximum, positions zero
    set_cfg(NORM_FULL, 32'h0, 2, 127, 0, 1'b0, 32'h00010000);
    push_rand(128);
    drain();
    // image and position counts above the maxima, batch left open
    set_cfg(NORM_VALID, 32'h0, 2047, 1, 8191, 1'b1, 32'h7fffffff);
    push_rand(30);
    drain();
    // dimensions shrunk mid-batch: position counter beyond the new last value
    write_reg(CFG_NUM_POSITIONS, 3);
    write_reg(CFG_NUM_IMAGES, 1);
    push_rand(4);
    drain();
    set_cfg(NORM_PREFIXED, 32'h7fffffff, 1, 2, 2, 1'b0, 32'h80000000);
    push_rand(8);
    drain();
    set_cfg(NORM_PREFIXED, 32'h00008000, 1, 2, 2, 1'b1, 32'h00010000);
    push_rand(8);
    drain();

    while (rand_words < 800) begin
      if (rand_words > 650) calm = 1'b1;
      set_cfg($urandom_range(0, 7),
              $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h80000),
              $urandom_range(0, 3), $urandom_range(0, 4), $urandom_range(0, 6),
              $urandom_range(0, 1),
              $urandom_range(0, 2) == 0 ? $urandom : 32'($urandom_range(0, 32'h40000))
                                                     - 32'h20000);
      size = dim_of(imgs_r, MaxImages) * dim_of(chans_r, MaxChannels)
             * dim_of(poss_r, MaxPositions);
      size = size * $urandom_range(1, 3);
      push_rand(size);
      rand_words += size;
      drain();
    end

    drain();
    repeat (100) @(posedge clk_i);
    if (loss_q.size() > 0) report_mismatch("words never seen", loss_q.size(), 0);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
hdl/sll_pkg.sv
hdl/sll_div.sv
hdl/sll_dp.sv
hdl/sll_ctrl.sv
hdl/smooth_l1_loss_engine_core.sv
tb/sv/smooth_l1_loss_engine_core_tb.sv
